// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PFA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen outside reset
`define PFA_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== sv/pfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

   localparam int WORD_W     = 64;
   localparam int WORD_LOG   = 6;
   localparam int STRIDE_W   = 20;
   localparam int RUN_W      = 17;
   localparam int SKIP_W     = 7;
   localparam int PAGE_SHIFT = 12;
   localparam int BASE_W     = 28;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_USED  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_NO_RUN  = 2'd2;

   typedef struct packed {
      logic                done;
      logic [WORD_W-1:0]   pattern;
      logic [SKIP_W-1:0]   skip;
   } align_info_type;

endpackage

`default_nettype wire

// ===== sv/pfa_map_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfa_map_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [pfa_pkg::WORD_W-1:0]  rd_data,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [pfa_pkg::WORD_W-1:0]  wr_data
);
   import pfa_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/pfa_align_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfa_align_gen (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pfa_pkg::STRIDE_W-1:0]  stride,
   output pfa_pkg::align_info_type            info
);
   import pfa_pkg::*;

   logic                  busy_ff, busy_in;
   logic [STRIDE_W:0]     acc_ff, acc_in;
   logic [WORD_W-1:0]     pat_ff, pat_in;
   logic                  at_end;
   logic [STRIDE_W:0]     skip_wide;

   assign at_end = acc_ff >= (STRIDE_W+1)'(WORD_W);

   // multiples of the stride below one word, then 64 mod stride
   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      pat_in  = pat_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         pat_in  = '0;
      end else if (busy_ff) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            pat_in[acc_ff[WORD_LOG-1:0]] = 1'b1;
            acc_in = acc_ff + {1'b0, stride};
         end
      end
   end

   assign skip_wide = (acc_ff == (STRIDE_W+1)'(WORD_W)) ? '0 :
                      (STRIDE_W+1)'(WORD_W) + {1'b0, stride} - acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      pat_ff <= pat_in;
   end

   assign info = '{done: busy_ff && at_end, pattern: pat_ff, skip: skip_wide[SKIP_W-1:0]};

endmodule

`default_nettype wire

// ===== sv/pfa_word_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfa_word_scan #(
   parameter int ADDR_W = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          init,
   input  wire logic                          step,
   input  wire logic [pfa_pkg::WORD_W-1:0]    word,
   input  wire logic [ADDR_W-1:0]             word_idx,
   input  wire logic [pfa_pkg::RUN_W-1:0]     run,
   input  wire logic [pfa_pkg::STRIDE_W-1:0]  stride,
   input  wire pfa_pkg::align_info_type       info,
   output logic                               found,
   output logic [ADDR_W+pfa_pkg::WORD_LOG-1:0] found_page
);
   import pfa_pkg::*;

   localparam int PN_W = ADDR_W + WORD_LOG;

   logic                  carry_ff, carry_in;
   logic [PN_W-1:0]       scur_ff, scur_in;
   logic [RUN_W-1:0]      need_ff, need_in;
   logic [STRIDE_W-1:0]   dist_ff, dist_in;

   logic [WORD_W-1:0]     avail, run_mask, need_mask, win, cand;
   logic                  any_cand, fits, carry_done, carry_more, dist_ge;
   logic [WORD_LOG-1:0]   pos;
   logic [STRIDE_W-1:0]   skip_ext;
   logic [STRIDE_W:0]     dist_wide;

   always_comb begin
      avail = (dist_ff < STRIDE_W'(WORD_W)) ? (info.pattern << dist_ff[WORD_LOG-1:0]) : '0;
      run_mask = (run >= RUN_W'(WORD_W)) ? '1 :
                 (WORD_W'(1) << run[WORD_LOG-1:0]) - WORD_W'(1);
      need_mask = (need_ff >= RUN_W'(WORD_W)) ? '1 :
                  (WORD_W'(1) << need_ff[WORD_LOG-1:0]) - WORD_W'(1);
      for (int i = 0; i < WORD_W; i++) begin
         win[i] = ~|((word >> i) & run_mask);
      end
      cand = avail & win;
      any_cand = 1'b0;
      pos = '0;
      for (int i = WORD_W-1; i >= 0; i--) begin
         if (cand[i]) begin
            any_cand = 1'b1;
            pos = WORD_LOG'(i);
         end
      end
      fits = (RUN_W+1)'(pos) + (RUN_W+1)'(run) <= (RUN_W+1)'(WORD_W);
      carry_done = carry_ff && (need_ff <= RUN_W'(WORD_W)) && ((word & need_mask) == '0);
      carry_more = carry_ff && (need_ff > RUN_W'(WORD_W)) && (word == '0);
      skip_ext = STRIDE_W'(info.skip);
      dist_ge = dist_ff >= skip_ext;
      dist_wide = dist_ge ? ({1'b0, dist_ff} - {1'b0, skip_ext}) :
                  ({1'b0, dist_ff} + {1'b0, stride} - {1'b0, skip_ext});
   end

   always_comb begin
      carry_in   = carry_ff;
      scur_in    = scur_ff;
      need_in    = need_ff;
      dist_in    = dist_ff;
      found      = 1'b0;
      found_page = scur_ff;
      if (init) begin
         carry_in = 1'b0;
         dist_in  = '0;
      end else if (step) begin
         dist_in = dist_wide[STRIDE_W-1:0];
         priority if (carry_done) begin
            found    = 1'b1;
            carry_in = 1'b0;
         end else if (carry_more) begin
            need_in = need_ff - RUN_W'(WORD_W);
         end else if (any_cand) begin
            if (fits) begin
               found      = 1'b1;
               found_page = {word_idx, pos};
               carry_in   = 1'b0;
            end else begin
               carry_in = 1'b1;
               scur_in  = {word_idx, pos};
               need_in  = run - (RUN_W'(WORD_W) - RUN_W'(pos));
            end
         end else begin
            carry_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 1'b0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      scur_ff <= scur_in;
      need_ff <= need_in;
      dist_ff <= dist_in;
   end

endmodule

`default_nettype wire

// ===== sv/page_frame_bitmap_allocator.sv =====
// one item in flight; req_stall stays high until its result is loaded
// mark free / mark used: one read-modify-write of the map, read on accept and written in S_RMW
// rejected or ignored items: no map access, the result is loaded from S_FINISH
// allocate: stride setup in S_ALIGN, then one map word per cycle of scan (at most every map
//   word), then a read-modify-write of each map word of the run
// reset fills the map with used marks, one word a cycle, no item taken
`timescale 1ns / 1ps
`default_nettype none

module page_frame_bitmap_allocator #(
   parameter int PAGES = 65536
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [1:0]   req_func,
   input  wire logic [16:0]  req_run_pages,
   input  wire logic [31:0]  req_align_bytes,
   input  wire logic [15:0]  req_page_index,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [27:0]       rsp_base_address
);
   import pfa_pkg::*;
   `include "assert_macros.svh"

   localparam int WORDS  = (PAGES + WORD_W - 1) / WORD_W;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PN_W   = ADDR_W + WORD_LOG;
   localparam int EW     = PN_W + RUN_W;
   localparam int BW     = PN_W + BASE_W;
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ALIGN  = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_MARK   = 3'd4;
   localparam logic [2:0] S_RMW    = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [ADDR_W-1:0]      word_ff, word_in;
   logic [ADDR_W-1:0]      wr_word_ff, wr_word_in;
   logic                   wr_pend_ff, wr_pend_in;
   logic                   rd_done_ff, rd_done_in;
   logic                   set_ff, set_in;
   logic [WORD_LOG-1:0]    bit_ff, bit_in;
   logic [RUN_W-1:0]       run_ff, run_in;
   logic [STRIDE_W-1:0]    stride_ff, stride_in;
   logic [PN_W-1:0]        first_ff, first_in;
   logic [PN_W-1:0]        last_ff, last_in;
   logic [1:0]             status_ff, status_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [BASE_W-1:0]      rsp_base_ff, rsp_base_in;

   logic                   mem_rd_en, mem_wr_en;
   logic [ADDR_W-1:0]      mem_rd_addr, mem_wr_addr;
   logic [WORD_W-1:0]      mem_rd_data, mem_wr_data;

   logic                   accept, align_bad, idx_ok, rsp_load;
   logic                   align_start, scan_init, scan_step, scan_found;
   logic [PN_W-1:0]        scan_page;
   logic [31:0]            idx_wide;
   logic [ADDR_W-1:0]      idx_word;
   logic [EW-1:0]          end_wide;
   logic [BW-1:0]          base_wide;
   logic [WORD_LOG-1:0]    mark_lo, mark_hi;
   logic [WORD_W-1:0]      mark_mask, bit_mask;
   align_info_type         align_info;

   pfa_map_mem #(
      .DEPTH  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_map (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   pfa_align_gen u_align (
      .clock  (clock),
      .reset  (reset),
      .start  (align_start),
      .stride (stride_ff),
      .info   (align_info)
   );

   pfa_word_scan #(
      .ADDR_W (ADDR_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .init       (scan_init),
      .step       (scan_step),
      .word       (mem_rd_data),
      .word_idx   (word_ff),
      .run        (run_ff),
      .stride     (stride_ff),
      .info       (align_info),
      .found      (scan_found),
      .found_page (scan_page)
   );

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign align_bad = (req_align_bytes == '0) || (req_align_bytes[PAGE_SHIFT-1:0] != '0) ||
                      (req_run_pages == '0);
   assign idx_wide  = 32'(req_page_index);
   assign idx_ok    = idx_wide < 32'(PAGES);
   assign idx_word  = idx_wide[ADDR_W+WORD_LOG-1:WORD_LOG];
   assign end_wide  = EW'(scan_page) + EW'(run_ff) - EW'(1);
   assign base_wide = BW'(scan_page) << PAGE_SHIFT;

   assign mark_lo   = (wr_word_ff == first_ff[PN_W-1:WORD_LOG]) ?
                      first_ff[WORD_LOG-1:0] : '0;
   assign mark_hi   = (wr_word_ff == last_ff[PN_W-1:WORD_LOG]) ?
                      last_ff[WORD_LOG-1:0] : '1;
   assign mark_mask = ({WORD_W{1'b1}} << mark_lo) & ({WORD_W{1'b1}} >> (~mark_hi));
   assign bit_mask  = WORD_W'(1) << bit_ff;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      word_in     = word_ff;
      wr_word_in  = wr_word_ff;
      wr_pend_in  = wr_pend_ff;
      rd_done_in  = rd_done_ff;
      set_in      = set_ff;
      bit_in      = bit_ff;
      run_in      = run_ff;
      stride_in   = stride_ff;
      first_in    = first_ff;
      last_in     = last_ff;
      status_in   = status_ff;
      base_in     = base_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = word_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = wr_word_ff;
      mem_wr_data = '1;
      align_start = 1'b0;
      scan_init   = 1'b0;
      scan_step   = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               status_in = STATUS_OK;
               base_in   = '0;
               run_in    = req_run_pages;
               stride_in = req_align_bytes[31:PAGE_SHIFT];
               set_in    = req_func == FUNC_USED;
               unique case (req_func)
                  FUNC_ALLOC: begin
                     if (align_bad) begin
                        status_in = STATUS_INVALID;
                        state_in  = S_FINISH;
                     end else begin
                        align_start = 1'b1;
                        state_in    = S_ALIGN;
                     end
                  end
                  FUNC_FREE, FUNC_USED: begin
                     if (idx_ok) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_word;
                        word_in     = idx_word;
                        bit_in      = req_page_index[WORD_LOG-1:0];
                        state_in    = S_RMW;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_ALIGN: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            if (align_info.done) begin
               scan_init = 1'b1;
               word_in   = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            scan_step = 1'b1;
            if (word_ff != LAST_WORD) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = word_ff + ADDR_W'(1);
            end
            if (scan_found) begin
               first_in   = scan_page;
               last_in    = end_wide[PN_W-1:0];
               base_in    = base_wide[BASE_W-1:0];
               word_in    = scan_page[PN_W-1:WORD_LOG];
               rd_done_in = 1'b0;
               wr_pend_in = 1'b0;
               state_in   = S_MARK;
            end else if (word_ff == LAST_WORD) begin
               status_in = STATUS_NO_RUN;
               state_in  = S_FINISH;
            end else begin
               word_in = word_ff + ADDR_W'(1);
            end
         end
         S_MARK: begin
            if (!rd_done_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = word_ff;
               word_in     = word_ff + ADDR_W'(1);
               wr_word_in  = word_ff;
               wr_pend_in  = 1'b1;
               if (word_ff == last_ff[PN_W-1:WORD_LOG]) begin
                  rd_done_in = 1'b1;
               end
            end else begin
               wr_pend_in = 1'b0;
            end
            if (wr_pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_word_ff;
               mem_wr_data = mem_rd_data | mark_mask;
            end
            if (rd_done_ff && wr_pend_ff) begin
               state_in = S_FINISH;
            end
         end
         S_RMW: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = word_ff;
            mem_wr_data = set_ff ? (mem_rd_data | bit_mask) : (mem_rd_data & ~bit_mask);
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_status_in = rsp_load ? status_ff : rsp_status_ff;
   assign rsp_base_in   = rsp_load ? base_ff : rsp_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         rd_done_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wr_pend_ff   <= wr_pend_in;
         rd_done_ff   <= rd_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      wr_word_ff    <= wr_word_in;
      set_ff        <= set_in;
      bit_ff        <= bit_in;
      run_ff        <= run_in;
      stride_ff     <= stride_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_base_address = rsp_base_ff;

   `PFA_NEVER(a_no_same_entry,
      mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr),
      "map read and write hit one entry")
   `PFA_ASSERT(a_base_only_ok,
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_base_address == '0,
      "nonzero base on error")
   `PFA_ASSERT(a_mark_in_run,
      mem_wr_en && (state_ff == S_MARK) |-> (mem_wr_addr >= first_ff[PN_W-1:WORD_LOG]) &&
      (mem_wr_addr <= last_ff[PN_W-1:WORD_LOG]),
      "run write outside run")
   `PFA_ASSERT(a_found_in_scan, scan_found |-> state_ff == S_SCAN, "run found outside scan")

endmodule

`default_nettype wire

// ===== tb/sv/pfa_reply_checker.sv =====
`timescale 1ns / 1ps

module pfa_reply_checker #(
   parameter int PAGES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [16:0] req_run_pages,
   input  logic [31:0] req_align_bytes,
   input  logic [15:0] req_page_index,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [27:0] rsp_base_address,
   output int          fail_count,
   output int          pending_items
);
   import pfa_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [27:0] base_address;
   } frame_reply_type;

   // one bit per page frame, set means used
   bit              page_used [PAGES];
   frame_reply_type replies_due [$];

   function automatic frame_reply_type predict_reply(input logic [1:0] func,
         input logic [16:0] run_pages, input logic [31:0] align_bytes,
         input logic [15:0] page_index);
      frame_reply_type reply;
      int unsigned     stride, size, start, i, k;
      reply.status = STATUS_OK;
      reply.base_address = '0;
      case (func)
         FUNC_ALLOC: begin
            if (align_bytes == 0 || align_bytes[11:0] != 0 || run_pages == 0) begin
               reply.status = STATUS_INVALID;
               return reply;
            end
            stride = align_bytes >> 12;
            size = 0;
            start = 0;
            // first fit from page 0, a run may only open on an aligned page
            for (i = 0; i < PAGES; i++) begin
               if (page_used[i]) begin
                  size = 0;
               end else if (size != 0 || i % stride == 0) begin
                  if (size == 0) start = i;
                  size++;
                  if (size == run_pages) begin
                     for (k = start; k <= i; k++) page_used[k] = 1'b1;
                     reply.base_address = 28'(start) << 12;
                     return reply;
                  end
               end
            end
            reply.status = STATUS_NO_RUN;
         end
         FUNC_FREE: begin
            if (page_index < PAGES) page_used[page_index] = 1'b0;
         end
         FUNC_USED: begin
            if (page_index < PAGES) page_used[page_index] = 1'b1;
         end
         default: ;
      endcase
      return reply;
   endfunction

   always @(posedge clock) begin
      frame_reply_type got, want;
      if (reset) begin
         for (int p = 0; p < PAGES; p++) page_used[p] = 1'b1;
         replies_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.base_address = rsp_base_address;
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected item: status %0d base_address %h",
                           $realtime, got.status, got.base_address);
            end else begin
               want = replies_due.pop_front();
               if (got.status !== want.status || got.base_address !== want.base_address) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch: status exp %0d got %0d, base_address exp %h got %h",
                              $realtime, want.status, got.status,
                              want.base_address, got.base_address);
               end
            end
         end
         if (req_valid && !req_stall)
            replies_due.push_back(predict_reply(req_func, req_run_pages,
                                                req_align_bytes, req_page_index));
      end
      pending_items <= replies_due.size();
   end

endmodule

// ===== tb/sv/page_frame_bitmap_allocator_tb.sv =====
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_tb;
   import pfa_pkg::*;

   localparam int         PAGES     = 65536;
   localparam int         N_RANDOM  = 557;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_NONE;
   logic [16:0] req_run_pages = '0;
   logic [31:0] req_align_bytes = '0;
   logic [15:0] req_page_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [27:0] rsp_base_address;
   int          fail_count;
   int          pending_items;
   bit          steady = 1'b0;

   page_frame_bitmap_allocator #(.PAGES(PAGES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_run_pages(req_run_pages),
      .req_align_bytes(req_align_bytes),
      .req_page_index(req_page_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_base_address(rsp_base_address)
   );

   pfa_reply_checker #(.PAGES(PAGES)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_run_pages(req_run_pages),
      .req_align_bytes(req_align_bytes),
      .req_page_index(req_page_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_base_address(rsp_base_address),
      .fail_count(fail_count),
      .pending_items(pending_items)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 19);
   end

   task automatic send_item(input logic [1:0] func, input logic [16:0] run_pages,
         input logic [31:0] align_bytes, input logic [15:0] page_index);
      if (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_run_pages <= run_pages;
      req_align_bytes <= align_bytes;
      req_page_index <= page_index;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [15:0] pick_page();
      if ($urandom_range(99) < 90) return 16'($urandom_range(511));
      return 16'($urandom_range(65535));
   endfunction

   initial begin
      int unsigned pick;
      int          waited;
      logic [1:0]  func;
      logic [16:0] run_pages;
      logic [31:0] align_bytes;
      logic [15:0] page_index;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // full map, bad arguments, unused selector
      send_item(FUNC_ALLOC, 17'd1, 32'd4096, 16'd0);
      send_item(FUNC_ALLOC, 17'd1, 32'd0, 16'd0);
      send_item(FUNC_ALLOC, 17'd1, 32'd4097, 16'd0);
      send_item(FUNC_ALLOC, 17'd1, 32'hFFFF_F800, 16'd0);
      send_item(FUNC_ALLOC, 17'd0, 32'd4096, 16'd0);
      send_item(FUNC_NONE, 17'h1_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(FUNC_FREE, 17'd0, 32'd0, 16'hFFFF);
      // largest alignment, only page 0 qualifies and it is used
      send_item(FUNC_ALLOC, 17'd1, 32'hFFFF_F000, 16'd0);
      for (int p = 0; p <= 7; p++)
         if (p != 3) send_item(FUNC_FREE, 17'd0, 32'd0, 16'(p));
      send_item(FUNC_ALLOC, 17'd3, 32'd4096, 16'd0);
      send_item(FUNC_ALLOC, 17'd2, 32'd8192, 16'd0);
      send_item(FUNC_ALLOC, 17'd1, 32'hFFFF_F000, 16'd0);
      send_item(FUNC_ALLOC, 17'd65536, 32'd4096, 16'd0);
      send_item(FUNC_USED, 17'd0, 32'd0, 16'd6);
      send_item(FUNC_ALLOC, 17'd1, 32'd4096, 16'd0);
      send_item(FUNC_ALLOC, 17'd1, 32'd4096, 16'd0);
      send_item(FUNC_USED, 17'd0, 32'd0, 16'hFFFF);

      for (int n = 0; n < N_RANDOM; n++) begin
         steady = (n >= 200 && n < 330);
         run_pages = 17'($urandom_range(65536));
         align_bytes = $urandom;
         page_index = 16'($urandom_range(65535));
         pick = $urandom_range(99);
         if (pick < 45) begin
            func = FUNC_FREE;
            page_index = pick_page();
         end else if (pick < 60) begin
            func = FUNC_USED;
            page_index = pick_page();
         end else if (pick < 90) begin
            func = FUNC_ALLOC;
            pick = $urandom_range(99);
            if (pick < 80) run_pages = 17'($urandom_range(8, 1));
            else if (pick < 95) run_pages = 17'($urandom_range(64, 9));
            else run_pages = 17'($urandom_range(65536, 1));
            pick = $urandom_range(99);
            if (pick < 70) align_bytes = 32'd4096 << $urandom_range(4);
            else if (pick < 85) align_bytes = 32'd4096 * $urandom_range(7, 1);
            else align_bytes = $urandom & 32'hFFFF_F000;
         end else if (pick < 97) begin
            func = FUNC_ALLOC;
            case ($urandom_range(2))
               0: align_bytes = '0;
               1: align_bytes[$urandom_range(11)] = 1'b1;
               default: begin
                  run_pages = '0;
                  align_bytes = 32'd4096 << $urandom_range(4);
               end
            endcase
         end else begin
            func = FUNC_NONE;
         end
         send_item(func, run_pages, align_bytes, page_index);
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      waited = 0;
      while (pending_items != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_items == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
